@@ rtl/block_revoke_hash_table_assert.svh @@
// Assertion macros used by the checker file.
`ifndef BLOCK_REVOKE_HASH_TABLE_ASSERT_SVH
`define BLOCK_REVOKE_HASH_TABLE_ASSERT_SVH

// Assert an implication that must hold on every rising clock edge outside reset.
`define BRH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assert an implication whose consequence is checked in the next cycle.
`define BRH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/brht_pkg.sv @@
// ----------------------------------------------------------------------------
// brht_pkg
// Shared types, constants and the bucket hash for the revoke hash table.
// ----------------------------------------------------------------------------
package brht_pkg;

   localparam int unsigned BUCKETS_DEFAULT = 256;
   localparam int unsigned WAYS_DEFAULT    = 4;
   localparam int          HASH_SHIFT_A    = 6;
   localparam int          HASH_SHIFT_B    = 13;
   localparam int          HASH_SHIFT_C    = 12;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [2:0] OP_REVOKE = 3'd0;
   localparam logic [2:0] OP_CANCEL = 3'd1;
   localparam logic [2:0] OP_SET    = 3'd2;
   localparam logic [2:0] OP_TEST   = 3'd3;
   localparam logic [2:0] OP_POP    = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Classified operation handed from the front to the back.
   typedef enum logic [2:0] {
      KIND_INSERT,
      KIND_SET,
      KIND_CANCEL,
      KIND_TEST,
      KIND_POP,
      KIND_CLEAR,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] block;
      logic [31:0] sequence_id;
      logic [31:0] hash;
   } cmd_type;

   // Logical shift by a signed count; negative counts shift right.
   function automatic logic [31:0] shift_signed(input logic [31:0] v, input int count);
      logic [31:0] r;
      r = '0;
      if (count >= 0) begin
         if (count < 32) r = v << count;
      end else begin
         if (-count < 32) r = v >> (-count);
      end
      return r;
   endfunction

   function automatic logic [31:0] hash_of(input logic [31:0] b, input int s);
      return shift_signed(b, s - HASH_SHIFT_A) ^ (b >> HASH_SHIFT_B) ^
             shift_signed(b, s - HASH_SHIFT_C);
   endfunction

   // a later than b under wraparound order
   function automatic logic seq_later(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

endpackage

@@ rtl/brht_front.sv @@
// ----------------------------------------------------------------------------
// brht_front
// Accepts commands, decodes the opcode and hashes the block number.
// ----------------------------------------------------------------------------
module brht_front #(
   parameter int unsigned BUCKETS = brht_pkg::BUCKETS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        opcode,
   input  logic [31:0]       block_number,
   input  logic [31:0]       sequence_id,
   output logic              cmd_valid,
   output brht_pkg::cmd_type cmd
);

   localparam int HASH_BITS = $clog2(BUCKETS);

   logic              cmd_valid_ff;
   brht_pkg::cmd_type cmd_ff;
   brht_pkg::cmd_type cmd_in;

   always_comb begin
      cmd_in.block       = block_number;
      cmd_in.sequence_id = sequence_id;
      cmd_in.hash        = brht_pkg::hash_of(block_number, HASH_BITS);
      case (opcode)
         brht_pkg::OP_REVOKE: cmd_in.kind = brht_pkg::KIND_INSERT;
         brht_pkg::OP_CANCEL: cmd_in.kind = brht_pkg::KIND_CANCEL;
         brht_pkg::OP_SET:    cmd_in.kind = brht_pkg::KIND_SET;
         brht_pkg::OP_TEST:   cmd_in.kind = brht_pkg::KIND_TEST;
         brht_pkg::OP_POP:    cmd_in.kind = brht_pkg::KIND_POP;
         brht_pkg::OP_CLEAR:  cmd_in.kind = brht_pkg::KIND_CLEAR;
         default:             cmd_in.kind = brht_pkg::KIND_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= accept;
      end
      if (accept) cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

@@ rtl/brht_queue.sv @@
// ----------------------------------------------------------------------------
// brht_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module brht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brht_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output brht_pkg::cmd_type head
);

   localparam int DEPTH = brht_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   brht_pkg::cmd_type       slot_ff [DEPTH];
   logic [PTR_BITS-1:0]     rd_ff, rd_in, wr_ff, wr_in;
   logic [PTR_BITS:0]       count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      rd_in    = pop  ? bump(rd_ff) : rd_ff;
      wr_in    = push ? bump(wr_ff) : wr_ff;
      count_in = count_ff + {{PTR_BITS{1'b0}}, push} - {{PTR_BITS{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

   assign not_empty = count_ff != '0;
   assign full      = count_ff == (PTR_BITS+1)'(DEPTH);
   assign head      = slot_ff[rd_ff];

endmodule

@@ rtl/brht_back.sv @@
// ----------------------------------------------------------------------------
// brht_back
// Carries out table operations: reads a bucket row, compares ways, writes back.
// Pop and clear sweep the valid rows one bucket per cycle.
// ----------------------------------------------------------------------------
module brht_back #(
   parameter int unsigned BUCKETS = brht_pkg::BUCKETS_DEFAULT,
   parameter int unsigned WAYS    = brht_pkg::WAYS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  brht_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              rsp_strobe,
   output logic              rsp_hit,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_out_block,
   output logic [31:0]       rsp_out_sequence
);

   localparam int BKT_BITS = $clog2(BUCKETS);
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [BKT_BITS-1:0] LAST_BKT = BKT_BITS'(BUCKETS - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_SCAN,
      ST_POPRD,
      ST_POPOUT
   } state_type;

   typedef logic [WAYS-1:0][31:0] row_type;

   // memory rows: one bucket per row, read registered
   row_type         mem_block    [BUCKETS];
   row_type         mem_sequence [BUCKETS];
   logic [WAYS-1:0] mem_valid    [BUCKETS];

   state_type           state_ff;
   brht_pkg::cmd_type   cmd_ff;
   logic [BKT_BITS-1:0] bkt_ff;
   logic [BKT_BITS-1:0] scan_ff;
   logic [BKT_BITS-1:0] tag_ff;
   logic                live_ff;
   logic [WAY_BITS-1:0] pway_ff;
   row_type             rd_block_ff, rd_seq_ff;
   logic [WAYS-1:0]     vrow_ff;
   logic                rsp_strobe_ff, rsp_hit_ff;
   logic [1:0]          rsp_status_ff;
   logic [31:0]         rsp_block_ff, rsp_seq_ff;

   // comparison over the row that was read
   logic                match_any, free_any;
   logic [WAY_BITS-1:0] match_way, free_way;
   logic [WAY_BITS-1:0] scan_way;
   logic                scan_any;

   // valid row port
   logic                v_we;
   logic [BKT_BITS-1:0] v_addr, rd_addr;
   logic [WAYS-1:0]     v_wdata;

   always_comb begin
      match_any = 1'b0;
      match_way = '0;
      free_any  = 1'b0;
      free_way  = '0;
      scan_any  = 1'b0;
      scan_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (vrow_ff[w] && rd_block_ff[w] == cmd_ff.block) begin
            match_any = 1'b1;
            match_way = WAY_BITS'(w);
         end
         if (!vrow_ff[w]) begin
            free_any = 1'b1;
            free_way = WAY_BITS'(w);
         end
         if (vrow_ff[w]) begin
            scan_any = 1'b1;
            scan_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      v_we    = 1'b0;
      v_addr  = bkt_ff;
      v_wdata = vrow_ff;
      rd_addr = (state_ff == ST_SCAN) ? scan_ff : bkt_ff;
      case (state_ff)
         ST_INIT: begin
            v_we    = 1'b1;
            v_addr  = scan_ff;
            v_wdata = '0;
         end
         ST_EXEC: begin
            if ((cmd_ff.kind == brht_pkg::KIND_INSERT || cmd_ff.kind == brht_pkg::KIND_SET) &&
                !match_any && free_any) begin
               v_we    = 1'b1;
               v_wdata = vrow_ff | (WAYS'(1) << free_way);
            end
            if (cmd_ff.kind == brht_pkg::KIND_CANCEL && match_any) begin
               v_we    = 1'b1;
               v_wdata = vrow_ff & ~(WAYS'(1) << match_way);
            end
         end
         ST_SCAN: begin
            if (cmd_ff.kind == brht_pkg::KIND_CLEAR) begin
               v_we    = 1'b1;
               v_addr  = scan_ff;
               v_wdata = '0;
            end else if (live_ff && scan_any) begin
               v_we    = 1'b1;
               v_addr  = tag_ff;
               v_wdata = vrow_ff & ~(WAYS'(1) << scan_way);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (v_we) mem_valid[v_addr] <= v_wdata;
      vrow_ff <= mem_valid[rd_addr];
   end

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         scan_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_INIT: begin
               if (scan_ff == LAST_BKT) begin
                  state_ff <= ST_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff  <= cmd;
                  bkt_ff  <= cmd.hash[BKT_BITS-1:0];
                  scan_ff <= '0;
                  live_ff <= 1'b0;
                  case (cmd.kind)
                     brht_pkg::KIND_POP,
                     brht_pkg::KIND_CLEAR: state_ff <= ST_SCAN;
                     brht_pkg::KIND_NOP: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_hit_ff    <= 1'b0;
                        rsp_status_ff <= brht_pkg::STATUS_OK;
                        rsp_block_ff  <= '0;
                        rsp_seq_ff    <= '0;
                     end
                     default: state_ff <= ST_READ;
                  endcase
               end
            end
            ST_READ: begin
               rd_block_ff <= mem_block[bkt_ff];
               rd_seq_ff   <= mem_sequence[bkt_ff];
               state_ff    <= ST_EXEC;
            end
            ST_EXEC: begin
               rsp_strobe_ff <= 1'b1;
               rsp_hit_ff    <= 1'b0;
               rsp_status_ff <= brht_pkg::STATUS_OK;
               rsp_block_ff  <= '0;
               rsp_seq_ff    <= '0;
               state_ff      <= ST_IDLE;
               case (cmd_ff.kind)
                  brht_pkg::KIND_INSERT,
                  brht_pkg::KIND_SET: begin
                     if (!match_any && !free_any) begin
                        rsp_status_ff <= brht_pkg::STATUS_FULL;
                     end
                  end
                  brht_pkg::KIND_CANCEL: begin
                     rsp_hit_ff <= match_any;
                  end
                  brht_pkg::KIND_TEST: begin
                     rsp_hit_ff <= match_any &&
                        !brht_pkg::seq_later(cmd_ff.sequence_id, rd_seq_ff[match_way]);
                  end
                  default: ;
               endcase
            end
            ST_SCAN: begin
               if (cmd_ff.kind == brht_pkg::KIND_CLEAR) begin
                  if (scan_ff == LAST_BKT) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_hit_ff    <= 1'b0;
                     rsp_status_ff <= brht_pkg::STATUS_OK;
                     rsp_block_ff  <= '0;
                     rsp_seq_ff    <= '0;
                     state_ff      <= ST_IDLE;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                  end
               end else if (live_ff && scan_any) begin
                  pway_ff  <= scan_way;
                  bkt_ff   <= tag_ff;
                  state_ff <= ST_POPRD;
               end else if (live_ff && tag_ff == LAST_BKT) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_hit_ff    <= 1'b0;
                  rsp_status_ff <= brht_pkg::STATUS_EMPTY;
                  rsp_block_ff  <= '0;
                  rsp_seq_ff    <= '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  // row of scan_ff arrives next cycle, tagged by tag_ff
                  tag_ff  <= scan_ff;
                  live_ff <= 1'b1;
                  if (scan_ff != LAST_BKT) scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_POPRD: begin
               rd_block_ff <= mem_block[bkt_ff];
               rd_seq_ff   <= mem_sequence[bkt_ff];
               state_ff    <= ST_POPOUT;
            end
            ST_POPOUT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_hit_ff    <= 1'b1;
               rsp_status_ff <= brht_pkg::STATUS_OK;
               rsp_block_ff  <= rd_block_ff[pway_ff];
               rsp_seq_ff    <= rd_seq_ff[pway_ff];
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // row write-back for inserts and sequence updates
   always_ff @(posedge clock) begin
      if (!reset && state_ff == ST_EXEC) begin
         if (cmd_ff.kind == brht_pkg::KIND_INSERT || cmd_ff.kind == brht_pkg::KIND_SET) begin
            if (match_any) begin
               if (cmd_ff.kind == brht_pkg::KIND_INSERT ||
                   brht_pkg::seq_later(cmd_ff.sequence_id, rd_seq_ff[match_way])) begin
                  mem_sequence[bkt_ff][match_way] <= cmd_ff.sequence_id;
               end
            end else if (free_any) begin
               mem_block[bkt_ff][free_way]    <= cmd_ff.block;
               mem_sequence[bkt_ff][free_way] <= cmd_ff.sequence_id;
            end
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_block    = rsp_block_ff;
   assign rsp_out_sequence = rsp_seq_ff;

endmodule

@@ rtl/block_revoke_hash_table.sv @@
// ----------------------------------------------------------------------------
// block_revoke_hash_table
// Set-associative table of revoked block numbers with transaction sequences.
// ----------------------------------------------------------------------------
// Usage: drive req_opcode, req_block_number and req_sequence_id with start
// high; the transaction is taken on a clock edge where busy is low. Each
// transaction yields one result on the rsp_ ports for one cycle, marked by
// rsp_strobe; the receiver must take it then, it cannot stall.
// Bucket operations (revoke, cancel, set, test) pass from acceptance to
// strobe through the front register, queue, bucket row read, compare and
// write-back. The back end works on one operation at a time; transactions
// taken meanwhile wait in the queue. Pop reads one bucket's valid row per
// cycle through a registered read, then reads the found bucket's row;
// clear writes one bucket per cycle.
// Unused opcodes answer with all zeros.
// Reset starts a clearing pass over the valid rows, one bucket per cycle;
// transactions taken meanwhile wait in the queue, and busy rises once the
// queue is full or the front register and the queue both hold a command.
// ----------------------------------------------------------------------------
module block_revoke_hash_table #(
   parameter int unsigned BUCKETS = brht_pkg::BUCKETS_DEFAULT,
   parameter int unsigned WAYS    = brht_pkg::WAYS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_block_number,
   input  logic [31:0] req_sequence_id,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_block,
   output logic [31:0] rsp_out_sequence
);

   logic              accept;
   logic              f_valid;
   brht_pkg::cmd_type f_cmd;
   logic              q_not_empty, q_full, q_pop;
   brht_pkg::cmd_type q_head;

   // hold off while the queue is full, or a command sits in the front register and the queue is not empty
   assign busy   = q_full || (f_valid && q_not_empty);
   assign accept = start && !busy;

   brht_front #(.BUCKETS(BUCKETS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_opcode),
      .block_number (req_block_number),
      .sequence_id  (req_sequence_id),
      .cmd_valid    (f_valid),
      .cmd          (f_cmd)
   );

   brht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_cmd  (f_cmd),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (q_head)
   );

   brht_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_not_empty),
      .cmd              (q_head),
      .cmd_take         (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_status       (rsp_status),
      .rsp_out_block    (rsp_out_block),
      .rsp_out_sequence (rsp_out_sequence)
   );

endmodule

@@ rtl/brht_checker.sv @@
// ----------------------------------------------------------------------------
// brht_checker
// Port-level checks on the revoke hash table.
// ----------------------------------------------------------------------------
`include "block_revoke_hash_table_assert.svh"

module brht_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_hit,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_out_block,
   input logic [31:0] rsp_out_sequence
);

   `BRH_ASSERT_IMPL(a_status_code, clock, reset, rsp_strobe, rsp_status <= brht_pkg::STATUS_EMPTY, "bad status")
   `BRH_ASSERT_IMPL(a_hit_ok, clock, reset, rsp_strobe && rsp_hit, rsp_status == brht_pkg::STATUS_OK, "hit with error")
   `BRH_ASSERT_IMPL(a_fields_zero, clock, reset, rsp_strobe && rsp_status != brht_pkg::STATUS_OK, rsp_out_block == 32'd0 && rsp_out_sequence == 32'd0 && !rsp_hit, "error result not zero")
   `BRH_ASSERT_NEXT(a_no_early_rsp, clock, reset, $fell(reset), !rsp_strobe, "result after reset")
   `BRH_ASSERT_IMPL(a_busy_known, clock, reset, start, !$isunknown(busy), "busy unknown")

endmodule

bind block_revoke_hash_table brht_checker u_brht_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_hit          (rsp_hit),
   .rsp_status       (rsp_status),
   .rsp_out_block    (rsp_out_block),
   .rsp_out_sequence (rsp_out_sequence)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Revoke hash table testbench
// Sends revoke, cancel, set, test, pop, clear and unused-opcode transactions to the
// table, predicts each response with a behavioral table, compares field by field.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned NBUCKETS = 256;
   localparam int unsigned NWAYS    = 4;
   localparam int unsigned NENTRIES = NBUCKETS * NWAYS;
   localparam int unsigned LOG2_BUCKETS = 8;

   // opcodes with no operation behind them
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic        hit;
      logic [1:0]  status;
      logic [31:0] blk;
      logic [31:0] seq;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = brht_pkg::OP_TEST;
   logic [31:0] req_block_number = '0;
   logic [31:0] req_sequence_id = '0;
   logic        rsp_strobe;
   logic        rsp_hit;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_block;
   logic [31:0] rsp_out_sequence;

   // predicted table contents
   logic        tbl_valid [NENTRIES];
   logic [31:0] tbl_block [NENTRIES];
   logic [31:0] tbl_seq   [NENTRIES];

   answer_type  pending_answers[$];
   int          mismatch_count = 0;
   bit          idle_enable = 1'b1;
   logic [31:0] known_blocks[$];

   block_revoke_hash_table u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_block_number(req_block_number),
      .req_sequence_id(req_sequence_id), .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit), .rsp_status(rsp_status),
      .rsp_out_block(rsp_out_block), .rsp_out_sequence(rsp_out_sequence)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] shift_by(logic [31:0] v, int count);
      if (count >= 0) return (count < 32) ? v << count : 32'd0;
      return (-count < 32) ? v >> (-count) : 32'd0;
   endfunction

   function automatic int unsigned bucket_base(logic [31:0] b);
      logic [31:0] h;
      h = shift_by(b, LOG2_BUCKETS - 6) ^ (b >> 13) ^ shift_by(b, LOG2_BUCKETS - 12);
      return (h & (NBUCKETS - 1)) * NWAYS;
   endfunction

   function automatic bit is_later(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d != 0 && !d[31];
   endfunction

   function automatic answer_type table_apply(logic [2:0] op, logic [31:0] b,
                                              logic [31:0] sq);
      answer_type  a;
      int          found;
      int          free_way;
      int unsigned base;
      a = '0;
      found = -1;
      free_way = -1;
      base = bucket_base(b);
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (tbl_valid[base + w] && tbl_block[base + w] == b) found = base + w;
         if (!tbl_valid[base + w]) free_way = base + w;
      end
      case (op)
         brht_pkg::OP_REVOKE, brht_pkg::OP_SET: begin
            if (found >= 0) begin
               if (op == brht_pkg::OP_REVOKE || is_later(sq, tbl_seq[found]))
                  tbl_seq[found] = sq;
            end else if (free_way < 0) begin
               a.status = brht_pkg::STATUS_FULL;
            end else begin
               tbl_valid[free_way] = 1'b1;
               tbl_block[free_way] = b;
               tbl_seq[free_way] = sq;
            end
         end
         brht_pkg::OP_CANCEL: begin
            if (found >= 0) begin
               tbl_valid[found] = 1'b0;
               a.hit = 1'b1;
            end
         end
         brht_pkg::OP_TEST: a.hit = (found >= 0) && !is_later(sq, tbl_seq[found]);
         brht_pkg::OP_POP: begin
            a.status = brht_pkg::STATUS_EMPTY;
            for (int i = 0; i < NENTRIES; i++) begin
               if (tbl_valid[i]) begin
                  tbl_valid[i] = 1'b0;
                  a.hit = 1'b1;
                  a.status = brht_pkg::STATUS_OK;
                  a.blk = tbl_block[i];
                  a.seq = tbl_seq[i];
                  break;
               end
            end
         end
         brht_pkg::OP_CLEAR: for (int i = 0; i < NENTRIES; i++) tbl_valid[i] = 1'b0;
         default: ;
      endcase
      return a;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_op(logic [2:0] op, logic [31:0] b, logic [31:0] sq);
      while (idle_enable && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_block_number <= b;
      req_sequence_id <= sq;
      // busy only moves after a rising edge, so its value here holds at the next one
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_answers.push_back(table_apply(op, b, sq));
      @(negedge clock);
   endtask

   task automatic drain_answers();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_answers.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         answer_type got;
         answer_type want;
         got = '{rsp_hit, rsp_status, rsp_out_block, rsp_out_sequence};
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want hit %b st %0d blk %h seq %h, got hit %b st %0d blk %h seq %h",
                     want.hit, want.status, want.blk, want.seq,
                     got.hit, got.status, got.blk, got.seq);
            end
         end
      end
   end

   // blocks sharing bucket 0: the hash of b is 4b ^ (b>>13) ^ (b>>4) masked
   function automatic logic [31:0] same_bucket_block(logic [31:0] seed);
      logic [31:0] b;
      b = seed;
      while (bucket_base(b) != 0) b++;
      return b;
   endfunction

   task automatic test_extremes();
      send_op(brht_pkg::OP_POP, 0, 0);
      send_op(brht_pkg::OP_TEST, 32'hFFFF_FFFF, 0);
      send_op(brht_pkg::OP_REVOKE, 32'h0, 32'h0);
      send_op(brht_pkg::OP_REVOKE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(brht_pkg::OP_REVOKE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_op(brht_pkg::OP_TEST, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_op(brht_pkg::OP_TEST, 32'hFFFF_FFFF, 32'h8000_0000);
      send_op(brht_pkg::OP_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(brht_pkg::OP_SET, 32'h0, 32'h8000_0000);
      send_op(brht_pkg::OP_SET, 32'h0, 32'h7FFF_FFFF);
      send_op(brht_pkg::OP_SET, 32'h1234_5678, 32'hAAAA_5555);
      send_op(brht_pkg::OP_CANCEL, 32'h0, 0);
      send_op(brht_pkg::OP_CANCEL, 32'h0, 0);
      send_op(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_SPARE_B, 32'h5555_AAAA, 32'h1);
      send_op(brht_pkg::OP_POP, 0, 0);
      send_op(brht_pkg::OP_POP, 0, 0);
   endtask

   task automatic test_full_bucket();
      logic [31:0] b;
      b = 0;
      for (int k = 0; k < NWAYS + 2; k++) begin
         b = same_bucket_block(b + 1);
         send_op(k % 2 ? brht_pkg::OP_SET : brht_pkg::OP_REVOKE, b, k);
      end
      send_op(brht_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(brht_pkg::OP_POP, 0, 0);
   endtask

   task automatic test_random(int count);
      logic [31:0] b;
      logic [31:0] sq;
      logic [2:0]  op;
      for (int n = 0; n < count; n++) begin
         idle_enable = !(n >= count / 3 && n < count / 2);
         if (n == count / 2) drain_answers();
         case ($urandom_range(99)) inside
            [0:29]:  op = brht_pkg::OP_REVOKE;
            [30:44]: op = brht_pkg::OP_SET;
            [45:64]: op = brht_pkg::OP_TEST;
            [65:79]: op = brht_pkg::OP_CANCEL;
            [80:94]: op = brht_pkg::OP_POP;
            [95:97]: op = brht_pkg::OP_CLEAR;
            default: op = 3'($urandom_range(7));
         endcase
         // mostly reuse a small set of blocks, many landing in one bucket
         if (known_blocks.size() > 0 && $urandom_range(3) != 0)
            b = known_blocks[$urandom_range(known_blocks.size() - 1)];
         else begin
            b = $urandom();
            if ($urandom_range(3) == 0) b = same_bucket_block(b);
            if (known_blocks.size() < 40) known_blocks.push_back(b);
         end
         sq = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(16)) + 32'h7FFF_FFF8;
         send_op(op, b, sq);
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < NENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_block[i] = '0;
         tbl_seq[i] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_full_bucket();
      test_random(680);
      drain_answers();
      repeat (600) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/brht_pkg.sv
rtl/brht_front.sv
rtl/brht_queue.sv
rtl/brht_back.sv
rtl/block_revoke_hash_table.sv
rtl/brht_checker.sv
test/testbench.sv
